[hw/rtl/oltbl_pkg.sv]
// Package for the ordered list table engine.
// Holds the word width, request opcodes and result status codes.
// No dependencies.
package oltbl_pkg;

  localparam int DATA_W = 32;

  // request opcodes, carried in s_tuser
  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_FIND       = 3'd4;
  localparam logic [2:0] OP_INSERT     = 3'd5;
  localparam logic [2:0] OP_ERASE      = 3'd6;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADPOS   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef logic [DATA_W-1:0] word_t;

endpackage

[hw/rtl/ordered_list_table_engine.sv]
// Ordered list table engine top level: request sequencer, count and result register.
// Depends on oltbl_pkg and oltbl_ram.
//
// A fixed-depth ordered list of unsigned 32-bit words. Each request transfer on the
// s_ side carries an opcode in s_tuser and a value and position in s_tdata; each
// request yields exactly one result transfer on the m_ side with a status, the
// found index and the element count after the operation. Push back, pop back and
// requests that fail a check finish in the decode step. Find, insert, push front,
// erase and pop front walk the element store one entry per cycle through its
// single read port: find reads from entry 0 up to the match or the last entry;
// insert and push front move the entries from the top down to the position, then
// write the new value; erase and pop front move the entries from position+1 up to
// the last one. The block takes one request at a time; a finished result waits in
// the output register and the next request is taken as soon as the sequencer is
// back to idle, which it reaches at the same edge that loads the result register.
module ordered_list_table_engine #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] value, [39:32] position
  input  logic [2:0]  s_tuser,   // [2:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [2:0] status, [10:3] found_index, [19:11] count, rest 0
);
  import oltbl_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 8) ? CW : 8;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SHUP   = 3'd2;
  localparam logic [2:0] S_SHDN   = 3'd3;
  localparam logic [2:0] S_FIND   = 3'd4;
  localparam logic [2:0] S_INSWR  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [2:0]    status_r, status_next;
  logic [7:0]    found_r, found_next;
  logic [2:0]    op_r;
  word_t         val_r;
  logic [7:0]    pos_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  word_t         ram_wdata;
  logic [AW-1:0] ram_raddr;
  word_t         ram_rdata;

  logic          in_xfer;
  logic          out_free;
  logic          is_full;
  logic          is_empty;
  logic [AW-1:0] pos_idx;
  logic [AW-1:0] last_idx;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign is_full  = (cnt == CW'(DEPTH));
  assign is_empty = (cnt == '0);
  assign pos_idx  = AW'(pos_r);
  assign last_idx = AW'(cnt - CW'(1));
  assign pos_x    = XW'(pos_r);
  assign cnt_x    = XW'(cnt);

  oltbl_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    ptr_next    = ptr;
    status_next = status_r;
    found_next  = found_r;
    ram_we      = 1'b0;
    ram_waddr   = ptr;
    ram_wdata   = val_r;
    ram_raddr   = ptr;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next  = S_DECODE;
          status_next = ST_OK;
          found_next  = '0;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (op_r)
          OP_PUSH_BACK: begin
            if (is_full) begin
              status_next = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(cnt);
              cnt_next  = cnt + CW'(1);
            end
          end
          OP_PUSH_FRONT, OP_INSERT: begin
            if (is_full) begin
              status_next = ST_FULL;
            end else if (pos_x > cnt_x) begin
              status_next = ST_BADPOS;
            end else if (pos_x == cnt_x) begin
              state_next = S_INSWR;
            end else begin
              // move entries pos..count-1 up, starting from the top
              ram_raddr  = last_idx;
              ptr_next   = last_idx;
              state_next = S_SHUP;
            end
          end
          OP_POP_FRONT, OP_ERASE: begin
            if (is_empty) begin
              status_next = ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
              status_next = ST_BADPOS;
            end else if (pos_idx == last_idx) begin
              cnt_next = cnt - CW'(1);
            end else begin
              // move entries pos+1..count-1 down, starting from the bottom
              ram_raddr  = pos_idx + AW'(1);
              ptr_next   = pos_idx + AW'(1);
              state_next = S_SHDN;
            end
          end
          OP_POP_BACK: begin
            if (is_empty) begin
              status_next = ST_EMPTY;
            end else begin
              cnt_next = cnt - CW'(1);
            end
          end
          OP_FIND: begin
            if (is_empty) begin
              status_next = ST_NOTFOUND;
            end else begin
              ram_raddr  = '0;
              ptr_next   = '0;
              state_next = S_FIND;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHUP: begin
        // rdata holds entry ptr; it moves to ptr+1
        ram_we    = 1'b1;
        ram_waddr = ptr + AW'(1);
        ram_wdata = ram_rdata;
        if (ptr == pos_idx) begin
          state_next = S_INSWR;
        end else begin
          ram_raddr = ptr - AW'(1);
          ptr_next  = ptr - AW'(1);
        end
      end
      S_INSWR: begin
        ram_we     = 1'b1;
        ram_waddr  = pos_idx;
        cnt_next   = cnt + CW'(1);
        state_next = S_DONE;
      end
      S_SHDN: begin
        // rdata holds entry ptr; it moves to ptr-1
        ram_we    = 1'b1;
        ram_waddr = ptr - AW'(1);
        ram_wdata = ram_rdata;
        if (ptr == last_idx) begin
          cnt_next   = cnt - CW'(1);
          state_next = S_DONE;
        end else begin
          ram_raddr = ptr + AW'(1);
          ptr_next  = ptr + AW'(1);
        end
      end
      S_FIND: begin
        // rdata holds entry ptr
        if (ram_rdata == val_r) begin
          found_next = 8'(ptr);
          state_next = S_DONE;
        end else if (ptr == last_idx) begin
          status_next = ST_NOTFOUND;
          state_next  = S_DONE;
        end else begin
          ram_raddr = ptr + AW'(1);
          ptr_next  = ptr + AW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    status_r <= status_next;
    found_r  <= found_next;
    if (in_xfer) begin
      op_r  <= s_tuser;
      val_r <= s_tdata[31:0];
      // front operations work at position zero
      if (s_tuser == OP_PUSH_FRONT || s_tuser == OP_POP_FRONT) begin
        pos_r <= '0;
      end else begin
        pos_r <= s_tdata[39:32];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= {4'b0000, 9'(cnt), found_r, status_r};
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("element count above depth");

  a_we_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state != S_IDLE && state != S_DONE))
    else $error("store written outside a request");

  a_find_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIND || state == S_SHDN) |-> !is_empty)
    else $error("store walk on an empty list");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[2:0] == ST_EMPTY) |-> (m_tdata[19:11] == 9'd0))
    else $error("empty status with nonzero count");

endmodule

[hw/rtl/oltbl_ram.sv]
// Element store: one write port and one read port with registered read data.
// Depends on oltbl_pkg for the word type.
module oltbl_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  oltbl_pkg::word_t wdata,
  input  logic [AW-1:0]   raddr,
  output oltbl_pkg::word_t rdata
);
  import oltbl_pkg::*;

  word_t mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
